[rtl/decimal_radix_sort_defines.svh]
// Assertion macros shared by the decimal radix sort RTL.
// Expects aclk and aresetn to be visible where a macro is used.
`ifndef DECIMAL_RADIX_SORT_DEFINES_SVH
`define DECIMAL_RADIX_SORT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/drs_pkg.sv]
// Package for the decimal radix sort: transaction payload structs, FSM states,
// bucket command struct. No dependencies.
package drs_pkg;

    localparam int VALUE_W = 16;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_in;
    } drs_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               last_out;
        logic               overflowed;
    } drs_out_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_COUNT,
        ST_PREFIX,
        ST_MOVE,
        ST_EMIT
    } drs_state_t;

    typedef struct packed {
        logic clear;
        logic incr;
        logic prefix;
    } drs_bkt_cmd_t;

endpackage

[rtl/drs_store.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the two ping-pong item stores. No package dependencies.
module drs_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/drs_divider.sv]
// Divide by the radix: quotient by reciprocal multiplication, digit as remainder.
// Combinational; no package dependencies.
module drs_divider #(
    parameter int WIDTH = 16,
    parameter int RADIX = 10
) (
    input  logic [WIDTH-1:0]         x,
    output logic [WIDTH-1:0]         quot,
    output logic [$clog2(RADIX)-1:0] digit
);

    localparam int L  = $clog2(RADIX);
    localparam int S  = WIDTH + L;
    localparam int MW = WIDTH + 1;
    localparam int PW = S + WIDTH;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << S) + 64'(RADIX) - 64'd1) / 64'(RADIX));

    logic [PW-1:0]    prod;
    logic [WIDTH-1:0] back;

    // floor(x * ceil(2^S / RADIX) / 2^S) is exact for every WIDTH-bit x
    assign prod  = {{S{1'b0}}, x} * {{(PW-MW){1'b0}}, RECIP};
    assign quot  = prod[S +: WIDTH];
    assign back  = WIDTH'(quot * WIDTH'(RADIX));
    assign digit = L'(x - back);

endmodule

[rtl/drs_buckets.sv]
// Bucket counters for one distribution pass: clear, count, prefix-sum into
// start slots, then hand out slots. Depends on drs_pkg.
module drs_buckets #(
    parameter int RADIX = 10,
    parameter int CNT_W = 7
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  drs_pkg::drs_bkt_cmd_t    cmd,
    input  logic [$clog2(RADIX)-1:0] sel,
    output logic [CNT_W-1:0]         slot
);
    import drs_pkg::*;

    logic [CNT_W-1:0] counts_reg  [RADIX];
    logic [CNT_W-1:0] counts_next [RADIX];
    logic [CNT_W-1:0] run_reg;
    logic [CNT_W-1:0] run_next;
    logic [CNT_W-1:0] rd;

    assign rd   = counts_reg[sel];
    assign slot = rd;

    always_comb begin
        counts_next = counts_reg;
        run_next    = run_reg;
        if (cmd.clear) begin
            for (int i = 0; i < RADIX; i++) begin
                counts_next[i] = '0;
            end
            run_next = '0;
        end else if (cmd.incr) begin
            counts_next[sel] = rd + CNT_W'(1);
        end else if (cmd.prefix) begin
            // turn the count into the bucket's first slot
            counts_next[sel] = run_reg;
            run_next         = run_reg + rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RADIX; i++) begin
                counts_reg[i] <= '0;
            end
            run_reg <= '0;
        end else begin
            counts_reg <= counts_next;
            run_reg    <= run_next;
        end
    end

endmodule

[rtl/decimal_radix_sort.sv]
// LSD radix sort. Load: 1 value per cycle. After the last value of a set, each
// pass runs a count read loop, a prefix over the buckets and a move read loop
// through the store's registered read port, one pass per digit of the largest
// value. Emit reads then registers each value; the next read waits until that
// value is in the output register, and loading holds while the receiver stalls.
// Reset (aresetn low, synchronous) empties the set; no clearing pass is needed.
`include "decimal_radix_sort_defines.svh"
module decimal_radix_sort #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 16,
    parameter int RADIX      = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  drs_pkg::drs_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output drs_pkg::drs_out_t m_data
);
    import drs_pkg::*;

    localparam int VW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DW    = $clog2(RADIX);

    drs_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [DW-1:0]    pidx_reg, pidx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             src_sel_reg, src_sel_next;
    logic [VW-1:0]    largest_reg, largest_next;
    logic [VW-1:0]    ql_reg, ql_next;
    logic             ovf_reg, ovf_next;
    logic             m_valid_reg, m_valid_next;
    drs_out_t         m_data_reg, m_data_next;

    logic             in_acc;
    logic [VW-1:0]    in_v;
    logic [VW-1:0]    new_largest;
    logic             has_room;
    logic             pass_done;
    logic             issue;
    logic             emit_issue;
    logic             out_load;
    logic             emit_final;
    logic             ren;
    logic [AW-1:0]    raddr;
    logic [2*VW-1:0]  even_rdata, odd_rdata, rdata;
    logic [VW-1:0]    r_val, r_q, q_div, ql_quot;
    logic [DW-1:0]    digit, ql_digit;
    drs_bkt_cmd_t     bkt_cmd;
    logic [DW-1:0]    bkt_sel;
    logic [CNT_W-1:0] slot;
    logic             even_we, odd_we;
    logic [AW-1:0]    even_waddr;
    logic [2*VW-1:0]  even_wdata, move_wdata;

    // each entry carries the value and its quotient by the current digit weight
    drs_store #(.DEPTH(CAPACITY), .WIDTH(2*VW)) u_even (
        .aclk  (aclk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .re    (ren),
        .raddr (raddr),
        .rdata (even_rdata)
    );

    drs_store #(.DEPTH(CAPACITY), .WIDTH(2*VW)) u_odd (
        .aclk  (aclk),
        .we    (odd_we),
        .waddr (slot[AW-1:0]),
        .wdata (move_wdata),
        .re    (ren),
        .raddr (raddr),
        .rdata (odd_rdata)
    );

    drs_divider #(.WIDTH(VW), .RADIX(RADIX)) u_item_div (
        .x     (r_q),
        .quot  (q_div),
        .digit (digit)
    );

    drs_divider #(.WIDTH(VW), .RADIX(RADIX)) u_pass_div (
        .x     (ql_reg),
        .quot  (ql_quot),
        .digit (ql_digit)
    );

    drs_buckets #(.RADIX(RADIX), .CNT_W(CNT_W)) u_buckets (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (bkt_cmd),
        .sel     (bkt_sel),
        .slot    (slot)
    );

    // shared decode
    assign s_ready     = (state_reg == ST_LOAD);
    assign in_acc      = s_valid && s_ready;
    assign in_v        = s_data.value[VW-1:0];
    assign has_room    = (cnt_reg < CNT_W'(CAPACITY));
    assign new_largest = (in_v > largest_reg) ? in_v : largest_reg;
    assign pass_done   = (idx_reg == cnt_reg) && !rd_pend_reg;
    assign issue       = ((state_reg == ST_COUNT) || (state_reg == ST_MOVE))
                         && (idx_reg < cnt_reg);
    assign emit_issue  = (state_reg == ST_EMIT) && !rd_pend_reg;
    assign out_load    = (state_reg == ST_EMIT) && rd_pend_reg
                         && (!m_valid_reg || m_ready);
    assign emit_final  = (idx_reg == cnt_reg - CNT_W'(1));
    assign ren         = issue || emit_issue;
    assign raddr       = idx_reg[AW-1:0];
    assign rdata       = src_sel_reg ? odd_rdata : even_rdata;
    assign r_val       = rdata[2*VW-1:VW];
    assign r_q         = rdata[VW-1:0];
    assign move_wdata  = {r_val, q_div};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_acc && s_data.last_in) state_next = ST_COUNT;
            end
            ST_COUNT: begin
                if (pass_done) state_next = ST_PREFIX;
            end
            ST_PREFIX: begin
                if (pidx_reg == DW'(RADIX - 1)) state_next = ST_MOVE;
            end
            ST_MOVE: begin
                if (pass_done) state_next = (ql_quot != '0) ? ST_COUNT : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load && emit_final) state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        pidx_next    = pidx_reg;
        rd_pend_next = rd_pend_reg;
        src_sel_next = src_sel_reg;
        largest_next = largest_reg;
        ql_next      = ql_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        bkt_cmd      = '0;
        bkt_sel      = digit;
        even_we      = 1'b0;
        odd_we       = 1'b0;
        even_waddr   = slot[AW-1:0];
        even_wdata   = move_wdata;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                even_waddr = cnt_reg[AW-1:0];
                even_wdata = {in_v, in_v};
                if (in_acc) begin
                    if (has_room) begin
                        even_we      = 1'b1;
                        cnt_next     = cnt_reg + CNT_W'(1);
                        largest_next = new_largest;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.last_in) begin
                        idx_next      = '0;
                        src_sel_next  = 1'b0;
                        ql_next       = has_room ? new_largest : largest_reg;
                        bkt_cmd.clear = 1'b1;
                    end
                end
            end
            ST_COUNT: begin
                rd_pend_next = issue;
                if (issue) idx_next = idx_reg + CNT_W'(1);
                bkt_cmd.incr = rd_pend_reg;
                if (pass_done) pidx_next = '0;
            end
            ST_PREFIX: begin
                bkt_sel        = pidx_reg;
                bkt_cmd.prefix = 1'b1;
                pidx_next      = pidx_reg + DW'(1);
                if (pidx_reg == DW'(RADIX - 1)) idx_next = '0;
            end
            ST_MOVE: begin
                rd_pend_next = issue;
                if (issue) idx_next = idx_reg + CNT_W'(1);
                // take a slot and drop the item into the other store
                bkt_cmd.incr = rd_pend_reg;
                even_we      = rd_pend_reg && src_sel_reg;
                odd_we       = rd_pend_reg && !src_sel_reg;
                if (pass_done) begin
                    idx_next      = '0;
                    src_sel_next  = !src_sel_reg;
                    ql_next       = ql_quot;
                    bkt_cmd.clear = (ql_quot != '0);
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    rd_pend_next             = 1'b0;
                    m_valid_next             = 1'b1;
                    m_data_next.sorted_value = VALUE_W'(r_val);
                    m_data_next.last_out     = emit_final;
                    m_data_next.overflowed   = ovf_reg;
                    idx_next                 = idx_reg + CNT_W'(1);
                    if (emit_final) begin
                        idx_next     = '0;
                        cnt_next     = '0;
                        largest_next = '0;
                        ovf_next     = 1'b0;
                    end
                end else if (emit_issue) begin
                    rd_pend_next = 1'b1;
                end
            end
            default: begin
                rd_pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            pidx_reg    <= '0;
            rd_pend_reg <= 1'b0;
            src_sel_reg <= 1'b0;
            largest_reg <= '0;
            ql_reg      <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            pidx_reg    <= pidx_next;
            rd_pend_reg <= rd_pend_next;
            src_sel_reg <= src_sel_next;
            largest_reg <= largest_next;
            ql_reg      <= ql_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `DRS_ASSERT_NXT(a_ovf_on_full, in_acc && !has_room, ovf_reg, "drop without overflow flag")
    `DRS_ASSERT_IMP(a_slot_range, (state_reg == ST_MOVE) && rd_pend_reg, slot < cnt_reg,
        "bucket slot beyond item count")
    `DRS_ASSERT_NXT(a_set_done, out_load && emit_final,
        (state_reg == ST_LOAD) && (cnt_reg == '0) && !ovf_reg,
        "set not retired after final result")
    `DRS_ASSERT_IMP(a_pass_digit, state_reg == ST_MOVE, int'(ql_digit) < RADIX,
        "pass digit out of range")

endmodule

[tb/sv/decimal_radix_sort_checker.sv]
// Checker for the decimal radix sort: watches both channels, predicts each sorted set
// and compares every result transaction in order. Depends on drs_pkg.
`timescale 1ns / 1ps
module decimal_radix_sort_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  drs_pkg::drs_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  drs_pkg::drs_out_t m_data,
    output int                fail_count,
    output int                outstanding,
    output int                sets_sorted,
    output int                dropped_sets,
    output int                results_checked
);
    import drs_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int DIGIT_BASE = 10;

    // Values of the set being loaded, in arrival order.
    logic [VALUE_W-1:0] set_vals [CAPACITY];
    int                 set_n;
    int                 set_max;
    logic               set_drop;

    drs_out_t sorted_q [$];
    drs_out_t want;
    int       mismatches;
    int       n_sets;
    int       n_dropped;
    int       n_checked;

    initial begin
        set_n      = 0;
        set_max    = 0;
        set_drop   = 1'b0;
        mismatches = 0;
        n_sets     = 0;
        n_dropped  = 0;
        n_checked  = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Stable LSD pass per decimal digit of the largest value, then queue the set.
    task automatic radix_sort_set();
        logic [VALUE_W-1:0] src [CAPACITY];
        logic [VALUE_W-1:0] dst [CAPACITY];
        int                 bucket_n  [DIGIT_BASE];
        int                 bucket_at [DIGIT_BASE];
        int                 weight;
        int                 run;
        int                 d;
        int                 i;
        drs_out_t           res;
        src    = set_vals;
        dst    = set_vals;
        weight = 1;
        do begin
            for (d = 0; d < DIGIT_BASE; d++) bucket_n[d] = 0;
            for (i = 0; i < set_n; i++) begin
                d = (int'(src[i]) / weight) % DIGIT_BASE;
                bucket_n[d]++;
            end
            run = 0;
            for (d = 0; d < DIGIT_BASE; d++) begin
                bucket_at[d] = run;
                run += bucket_n[d];
            end
            for (i = 0; i < set_n; i++) begin
                d = (int'(src[i]) / weight) % DIGIT_BASE;
                dst[bucket_at[d]] = src[i];
                bucket_at[d]++;
            end
            src = dst;
            weight *= DIGIT_BASE;
        end while (weight <= set_max);
        for (i = 0; i < set_n; i++) begin
            res.sorted_value = src[i];
            res.last_out     = (i == set_n - 1);
            res.overflowed   = set_drop;
            sorted_q.push_back(res);
        end
        n_sets++;
        if (set_drop) n_dropped++;
        set_n    = 0;
        set_max  = 0;
        set_drop = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                // Drop values past capacity, but still let the marked one close the set.
                if (set_n < CAPACITY) begin
                    set_vals[set_n] = s_data.value;
                    set_n++;
                    if (int'(s_data.value) > set_max) set_max = int'(s_data.value);
                end else begin
                    set_drop = 1'b1;
                end
                if (s_data.last_in) radix_sort_set();
            end
            if (m_valid && m_ready) begin
                if (sorted_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d", m_data.sorted_value));
                end else begin
                    want = sorted_q.pop_front();
                    if (m_data.sorted_value !== want.sorted_value)
                        report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                                  m_data.sorted_value, want.sorted_value));
                    if (m_data.last_out !== want.last_out)
                        report_mismatch($sformatf("last_out %b, expected %b on value %0d",
                                                  m_data.last_out, want.last_out,
                                                  want.sorted_value));
                    if (m_data.overflowed !== want.overflowed)
                        report_mismatch($sformatf("overflowed %b, expected %b on value %0d",
                                                  m_data.overflowed, want.overflowed,
                                                  want.sorted_value));
                    n_checked++;
                end
            end
        end
        fail_count      <= mismatches;
        outstanding     <= sorted_q.size();
        sets_sorted     <= n_sets;
        dropped_sets    <= n_dropped;
        results_checked <= n_checked;
    end

endmodule

[tb/sv/decimal_radix_sort_tb.sv]
// Top of the decimal radix sort testbench: clock, reset, stimulus and verdict.
// Depends on drs_pkg, decimal_radix_sort and decimal_radix_sort_checker.
`timescale 1ns / 1ps
module decimal_radix_sort_tb;
    import drs_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 300;
    localparam int RX_PARK_AT   = 30;
    localparam int RX_PARK_LEN  = 1500;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    drs_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    drs_out_t m_data;

    int fail_count;
    int outstanding;
    int sets_sorted;
    int dropped_sets;
    int results_checked;

    decimal_radix_sort dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    decimal_radix_sort_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .sets_sorted     (sets_sorted),
        .dropped_sets    (dropped_sets),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Spread values over every digit count, with some powers of ten and extremes.
    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 6))
            0: return VALUE_W'($urandom_range(0, 9));
            1: return VALUE_W'($urandom_range(0, 99));
            2: return VALUE_W'($urandom_range(0, 999));
            3: return VALUE_W'($urandom_range(0, 9999));
            4: begin
                case ($urandom_range(0, 6))
                    0: return VALUE_W'(0);
                    1: return VALUE_W'(1);
                    2: return VALUE_W'(10);
                    3: return VALUE_W'(100);
                    4: return VALUE_W'(1000);
                    5: return VALUE_W'(10000);
                    default: return '1;
                endcase
            end
            default: return VALUE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_item(input logic [VALUE_W-1:0] v, input logic lst, input int gap);
        drs_in_t item;
        item.value   = v;
        item.last_in = lst;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold the input idle until every predicted result has been taken.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Sender and verdict.
    initial begin
        logic [VALUE_W-1:0] spread_set [10];
        logic [VALUE_W-1:0] tie_set [4];
        int                 random_items;
        int                 set_idx;
        int                 size;
        int                 k;
        bit                 quiet;
        spread_set = '{16'hFFFF, 16'd0, 16'd10000, 16'd1000, 16'd100,
                       16'd10, 16'd1, 16'd9, 16'd99, 16'hFFFF};
        tie_set    = '{16'd20, 16'd3, 16'd20, 16'd1};
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single zero, extremes and powers of ten, ties, one-digit and
        // exact-power sets, a two-value set with a three-digit largest value.
        send_item(16'd0, 1'b1, 0);
        foreach (spread_set[i]) send_item(spread_set[i], i == 9, pick_gap());
        foreach (tie_set[i]) send_item(tie_set[i], i == 3, pick_gap());
        send_item(16'd9, 1'b1, pick_gap());
        send_item(16'd10, 1'b1, pick_gap());
        send_item(16'd5, 1'b0, 0);
        send_item(16'd100, 1'b1, 0);
        wait_until_drained();

        // Random sets; one exactly full, one that overruns so the marked value is dropped.
        random_items = 0;
        set_idx      = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (set_idx == 4) size = CAPACITY;
            else if (set_idx == 9) size = CAPACITY + 2;
            else if ($urandom_range(0, 4) == 0) size = $urandom_range(13, 40);
            else size = $urandom_range(1, 12);
            quiet = ($urandom_range(0, 3) == 0);
            for (k = 0; k < size; k++)
                send_item(rand_value(), k == size - 1, quiet ? 0 : pick_gap());
            random_items += size;
            if (set_idx >= 20 && $urandom_range(0, 5) == 0) wait_until_drained();
            set_idx++;
        end

        wait_until_drained();
        repeat (40) @(posedge aclk);
        $display("summary: %0d sets sorted, %0d of them overran capacity, %0d results checked",
                 sets_sorted, dropped_sets, results_checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("decimal_radix_sort_tb: PASS");
        end else begin
            $display("decimal_radix_sort_tb: FAIL");
        end
        $finish;
    end

    // Receiver: random stalls with quiet windows, plus one long park.
    initial begin
        int  stall;
        int  rx_count;
        int  cyc;
        bit  parked;
        stall    = 0;
        rx_count = 0;
        cyc      = 0;
        parked   = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (m_valid && m_ready) rx_count++;
            if (!parked && rx_count >= RX_PARK_AT) begin
                parked = 1'b1;
                stall  = RX_PARK_LEN;
            end else if (stall == 0 && (cyc % 512) >= 128 && $urandom_range(0, 3) == 0) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #2000000;
        $display("timeout: results still pending");
        $display("decimal_radix_sort_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/drs_pkg.sv
rtl/drs_store.sv
rtl/drs_divider.sv
rtl/drs_buckets.sv
rtl/decimal_radix_sort.sv
tb/sv/decimal_radix_sort_checker.sv
tb/sv/decimal_radix_sort_tb.sv
